// File: hdl/lcs_tu_pkg.sv
// ----------------------------------------------------------------------------
// lcs_tu_pkg
// Request and result types and action codes of the LCS threshold update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_tu_pkg;

	localparam int COLUMN_W = 16;
	localparam int SLOT_W   = 10;
	localparam int LENGTH_W = 11;

	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_REPLACE  = 2'd1;
	localparam logic [1:0] ACT_APPEND   = 2'd2;
	localparam logic [1:0] ACT_OVERFLOW = 2'd3;

	typedef struct packed {
		logic                new_problem;
		logic                new_row;
		logic [COLUMN_W-1:0] column;
	} lcs_req_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [SLOT_W-1:0]   slot;
		logic [LENGTH_W-1:0] lcs_length;
	} lcs_rsp_t;

endpackage

`default_nettype wire

// File: hdl/lcs_threshold_update_unit.sv
// ----------------------------------------------------------------------------
// lcs_threshold_update_unit
// Threshold table update of a Hunt-Szymanski LCS run, with a binary search
// over the table held in a single-port RAM.
//
//   Channel   Signals            Direction  Transfer
//   request   start, busy, req   in         start high while busy low
//   result    done, rsp          out        done high for one cycle
//
// A request is accepted in idle; the search and compare states run the
// binary search steps over slots 0 to the search limit, and a new request
// is taken only once busy is low. Each step is one read of the single RAM
// port; the update state writes the key on an append or a replace.
// The result strobe comes in the cycle after the write, while busy is low.
// Reset empties the table and clears the search limit; no clearing pass runs.
// The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_threshold_update_unit
	import lcs_tu_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int COLUMN_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire lcs_req_t req,
	output logic          done,
	output lcs_rsp_t      rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = COLUMN_BITS;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] limit_q;
	logic [LW-1:0] lo_q;
	logic [LW-1:0] hi_q;
	logic [LW-1:0] mid_q;
	logic [KW-1:0] key_q;
	logic          done_q;
	lcs_rsp_t      rsp_q;

	logic [63:0]   col_w;
	logic [KW-1:0] key_in;
	logic [LW-1:0] len_c;
	logic [LW-1:0] lim_a;
	logic [LW-1:0] lim_b;
	logic [LW-1:0] lim_c;

	logic [LW-1:0] nlo;
	logic [LW-1:0] nhi;
	logic [LW-1:0] nmid;

	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_addr;
	logic [KW-1:0] ram_rdata;

	logic          at_end;
	logic          is_full;
	logic          smaller;
	logic [1:0]    act;
	logic [LW-1:0] len_n;
	logic [LW-1:0] slot_out;
	logic [31:0]   slot_w;
	logic [31:0]   len_w;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Prepare the search range from the request flags.
	always_comb begin
		col_w  = 64'(req.column);
		key_in = col_w[KW-1:0];
		len_c  = req.new_problem ? '0 : len_q;
		lim_a  = req.new_problem ? '0 : limit_q;
		lim_b  = req.new_row ? len_c : lim_a;
		lim_c  = (lim_b > len_c) ? len_c : lim_b;
	end

	// One binary search step: narrow the range and pick the next probe.
	always_comb begin
		nlo = lo_q;
		nhi = hi_q;
		if (state_q == ST_CMP) begin
			if (ram_rdata < key_q) begin
				nlo = mid_q + LW'(1);
			end else begin
				nhi = mid_q;
			end
		end
		nmid = nlo + ((nhi - nlo) >> 1);
	end

	// Decide the table update once the found slot has been read.
	always_comb begin
		at_end   = (lo_q == len_q);
		is_full  = (len_q == LW'(TABLE_DEPTH));
		smaller  = (key_q < ram_rdata);
		act      = ACT_NONE;
		len_n    = len_q;
		slot_out = lo_q;
		if (at_end) begin
			if (is_full) begin
				act      = ACT_OVERFLOW;
				slot_out = LW'(TABLE_DEPTH - 1);
			end else begin
				act   = ACT_APPEND;
				len_n = len_q + LW'(1);
			end
		end else if (smaller) begin
			act = ACT_REPLACE;
		end
		slot_w = 32'(slot_out);
		len_w  = 32'(len_n);
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = '0;
		unique case (state_q)
			ST_SEARCH, ST_CMP: begin
				ram_re = 1'b1;
				if (nlo < nhi) begin
					ram_addr = nmid[AW-1:0];
				end else begin
					ram_addr = nlo[AW-1:0];
				end
			end
			ST_UPDATE: begin
				ram_addr = lo_q[AW-1:0];
				ram_we   = (act == ACT_APPEND) || (act == ACT_REPLACE);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			limit_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						len_q   <= len_c;
						limit_q <= lim_c;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH, ST_CMP: begin
					if (nlo < nhi) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					len_q   <= len_n;
					limit_q <= lo_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			lo_q  <= '0;
			hi_q  <= lim_c;
			key_q <= key_in;
		end
		if ((state_q == ST_SEARCH) || (state_q == ST_CMP)) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			mid_q <= nmid;
		end
		if (state_q == ST_UPDATE) begin
			rsp_q.action     <= act;
			rsp_q.slot       <= slot_w[SLOT_W-1:0];
			rsp_q.lcs_length <= len_w[LENGTH_W-1:0];
		end
	end

	lcs_tu_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(KW),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(key_q),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

// File: hdl/lcs_tu_ram.sv
// ----------------------------------------------------------------------------
// lcs_tu_ram
// Single-port synchronous RAM holding the threshold table, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_tu_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire
